// ===== sv/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants for the four-level page table walker: operation codes,
// entry bit positions and the default table pool size.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  // Pool size default and table geometry
  localparam int TABLE_PAGES_DEF   = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int FRAME_W           = 40;
  localparam int ENTRY_W           = 64;

  // Item field widths
  localparam int FUNC_W  = 2;
  localparam int VIRT_W  = 48;
  localparam int PHYS_W  = 52;
  localparam int FLAGS_W = 64;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FN_MAP    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UNMAP  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

  // Entry bits
  localparam int BIT_PRESENT  = 0;
  localparam int BIT_WRITABLE = 1;
  localparam int BIT_USER     = 2;

  // Frame address bits of an entry
  localparam logic [ENTRY_W-1:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;

endpackage

`default_nettype wire

// ===== sv/four_level_page_table_walker_unit.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit: radix page table lookup, map and unmap.
// A walk reads and checks the entry at each level, then loads the output register;
// a map that meets a missing level zero-sweeps a new 512-entry table and links it.
// Items are taken one at a time: no new item is accepted until the last result
// has been loaded into the output register; the entry memory is single-port.
// After reset a clearing pass zeroes all TABLE_PAGES*512 entries before any item.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker_unit #(
  parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration: pool_base_frame
  input  wire logic                      cfg_we,
  input  wire logic [ptw_pkg::FRAME_W-1:0] cfg_wdata,
  // request channel
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [167:0]              in_tdata,  // virt[47:0], phys_addr[99:48],
                                                    // flags[163:100], zero pad
  input  wire logic [ptw_pkg::FUNC_W-1:0] in_tuser, // func
  // result channel
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [55:0]                    out_tdata  // ok[0], phys_out[52:1],
                                                    // invalidate[53], zero pad
);

  import ptw_pkg::*;

  localparam int PW    = $clog2(TABLE_PAGES);
  localparam int NFW   = $clog2(TABLE_PAGES + 1);
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_ZERO  = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] LVL_LEAF = 2'd3;

  // Entry memory
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;

  // Control state
  logic [2:0]   state_r, state_nxt;
  logic [1:0]   lvl_r, lvl_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [PW-1:0] np_r, np_nxt;
  logic [NFW-1:0] nfp_r, nfp_nxt;
  logic [AW-1:0] sw_cnt_r, sw_cnt_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] base_r;

  // Item and result payload
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [VIRT_W-1:0]  virt_r, virt_nxt;
  logic [PHYS_W-1:0]  phys_r, phys_nxt;
  logic [FLAGS_W-1:0] flags_r, flags_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [PHYS_W-1:0]  res_phys_r, res_phys_nxt;
  logic               res_inv_r, res_inv_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [PHYS_W-1:0]  out_phys_r, out_phys_nxt;
  logic               out_inv_r, out_inv_nxt;

  // Walk helpers
  logic [IDX_W-1:0]   idx;
  logic               user_req;
  logic [FRAME_W-1:0] off;
  logic               off_ok;
  logic [FRAME_W-1:0] new_frame;
  logic [ENTRY_W-1:0] new_entry;

  // Index of the current level
  always_comb begin
    case (lvl_r)
      2'd0:    idx = virt_r[47:39];
      2'd1:    idx = virt_r[38:30];
      2'd2:    idx = virt_r[29:21];
      default: idx = virt_r[20:12];
    endcase
  end

  assign user_req  = (func_r == FN_MAP) && flags_r[BIT_USER];
  // Pool page named by the entry just read
  assign off       = rdata_r[51:12] - base_r;
  assign off_ok    = off < FRAME_W'(TABLE_PAGES);
  // Link entry for a freshly allocated table
  assign new_frame = base_r + {{(FRAME_W-PW){1'b0}}, np_r};
  assign new_entry = {12'd0, new_frame, 9'd0, user_req, 1'b1, 1'b1};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    page_nxt      = page_r;
    np_nxt        = np_r;
    nfp_nxt       = nfp_r;
    sw_cnt_nxt    = sw_cnt_r;
    func_nxt      = func_r;
    virt_nxt      = virt_r;
    phys_nxt      = phys_r;
    flags_nxt     = flags_r;
    res_ok_nxt    = res_ok_r;
    res_phys_nxt  = res_phys_r;
    res_inv_nxt   = res_inv_r;
    out_ok_nxt    = out_ok_r;
    out_phys_nxt  = out_phys_r;
    out_inv_nxt   = out_inv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = {page_r, idx};
    mem_wdata     = '0;

    case (state_r)
      // Zero the whole memory after reset
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sw_cnt_r;
        if (sw_cnt_r == AW'(DEPTH - 1)) begin
          sw_cnt_nxt = '0;
          state_nxt  = S_IDLE;
        end else begin
          sw_cnt_nxt = sw_cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tuser;
          virt_nxt  = in_tdata[47:0];
          phys_nxt  = in_tdata[99:48];
          flags_nxt = in_tdata[163:100];
          lvl_nxt   = 2'd0;
          page_nxt  = '0;
          if (in_tuser == FN_NONE) begin
            res_ok_nxt   = 1'b0;
            res_phys_nxt = '0;
            res_inv_nxt  = 1'b0;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        res_ok_nxt   = 1'b0;
        res_phys_nxt = '0;
        res_inv_nxt  = 1'b0;
        if (lvl_r != LVL_LEAF) begin
          if (!rdata_r[BIT_PRESENT]) begin
            // missing level: allocate a table on map while the pool has a free page, else fail
            if ((func_r == FN_MAP) && (nfp_r < NFW'(TABLE_PAGES))) begin
              np_nxt     = nfp_r[PW-1:0];
              nfp_nxt    = nfp_r + 1'b1;
              sw_cnt_nxt = '0;
              state_nxt  = S_ZERO;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            // mark existing intermediate user when asked
            if (user_req && !rdata_r[BIT_USER]) begin
              mem_we    = 1'b1;
              mem_wdata = rdata_r | (ENTRY_W'(1) << BIT_USER);
            end
            if (off_ok) begin
              page_nxt  = off[PW-1:0];
              lvl_nxt   = lvl_r + 1'b1;
              state_nxt = S_READ;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end else begin
          // leaf
          state_nxt = S_OUT;
          case (func_r)
            FN_MAP: begin
              mem_we      = 1'b1;
              mem_wdata   = {12'd0, phys_r} | flags_r | (ENTRY_W'(1) << BIT_PRESENT);
              res_ok_nxt  = 1'b1;
              res_inv_nxt = 1'b1;
            end
            FN_UNMAP: begin
              if (rdata_r[BIT_PRESENT]) begin
                mem_we      = 1'b1;
                res_ok_nxt  = 1'b1;
                res_inv_nxt = 1'b1;
              end
            end
            default: begin
              if (rdata_r[BIT_PRESENT]) begin
                res_ok_nxt   = 1'b1;
                res_phys_nxt = PHYS_W'(rdata_r & ADDR_MASK);
              end
            end
          endcase
        end
      end

      // Zero-fill the newly allocated table
      S_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = {np_r, sw_cnt_r[IDX_W-1:0]};
        if (sw_cnt_r[IDX_W-1:0] == {IDX_W{1'b1}}) begin
          sw_cnt_nxt = '0;
          state_nxt  = S_LINK;
        end else begin
          sw_cnt_nxt = sw_cnt_r + 1'b1;
        end
      end

      // Point the parent entry at the new table
      S_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = new_entry;
        page_nxt  = np_r;
        lvl_nxt   = lvl_r + 1'b1;
        state_nxt = S_READ;
      end

      // Hand the result to the output register
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_phys_nxt  = res_phys_r;
          out_inv_nxt   = res_inv_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory port: one access per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      lvl_r       <= '0;
      page_r      <= '0;
      np_r        <= '0;
      nfp_r       <= NFW'(1);
      sw_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      page_r      <= page_nxt;
      np_r        <= np_nxt;
      nfp_r       <= nfp_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    virt_r     <= virt_nxt;
    phys_r     <= phys_nxt;
    flags_r    <= flags_nxt;
    res_ok_r   <= res_ok_nxt;
    res_phys_r <= res_phys_nxt;
    res_inv_r  <= res_inv_nxt;
    out_ok_r   <= out_ok_nxt;
    out_phys_r <= out_phys_nxt;
    out_inv_r  <= out_inv_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_inv_r, out_phys_r, out_ok_r};

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: four-level page table walker
// Sends lookup, map and unmap requests over the request stream and checks
// every result against a local model of the table pool, its bump allocator
// and the pool base register. Phases run with the pool base at its highest
// value, at zero, at a random value and at the highest value again, with
// random gaps and stalls on both streams.
// ----------------------------------------------------------------------------

module testbench;
  import ptw_pkg::*;

  localparam int POOL_PAGES = TABLE_PAGES_DEF;
  localparam int STUCK_LIMIT = 60000;
  localparam logic [PHYS_W-1:0] PHYS_MAX = 52'hF_FFFF_FFFF_F000;
  localparam logic [FRAME_W-1:0] BASE_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VIRT_W-1:0]  virt;
    logic [PHYS_W-1:0]  phys_addr;
    logic [FLAGS_W-1:0] flags;
    logic               drain_first;  // hold this item until all results are back
  } walk_req_t;

  typedef struct packed {
    logic              ok;
    logic [PHYS_W-1:0] phys_out;
    logic              invalidate;
  } walk_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [FRAME_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [167:0] in_tdata = '0;  // virt, phys_addr, flags, zero pad
  logic [FUNC_W-1:0] in_tuser = FN_LOOKUP;  // func
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;  // ok, phys_out, invalidate, zero pad

  // Model state: table pool, allocator and pool base
  logic [ENTRY_W-1:0] pt_mem [POOL_PAGES*ENTRIES_PER_TABLE];
  int unsigned pt_next_page;
  logic [FRAME_W-1:0] pt_pool_base;

  walk_req_t request_q[$];
  walk_resp_t walk_results_q[$];
  walk_req_t cur_req;
  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0, send_calm = 0;
  int unsigned recv_wait = 0, recv_calm = 0;
  int unsigned stuck_cycles = 0;

  four_level_page_table_walker_unit #(
    .TABLE_PAGES(POOL_PAGES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One level down; allocates a cleared table on a map. Returns -1 on failure.
  function automatic int walk_level(int pg, logic [IDX_W-1:0] idx, bit create,
                                    bit want_user);
    int slot;
    int np;
    int k;
    logic [ENTRY_W-1:0] e;
    logic [FRAME_W-1:0] off;
    slot = pg * ENTRIES_PER_TABLE + idx;
    e = pt_mem[slot];
    if (!e[BIT_PRESENT]) begin
      if (!create || pt_next_page >= POOL_PAGES) return -1;
      np = pt_next_page;
      pt_next_page++;
      for (k = 0; k < ENTRIES_PER_TABLE; k++) pt_mem[np*ENTRIES_PER_TABLE + k] = '0;
      e = {12'h0, pt_pool_base + FRAME_W'(np), 12'h0};
      e[BIT_PRESENT] = 1'b1;
      e[BIT_WRITABLE] = 1'b1;
      e[BIT_USER] = want_user;
      pt_mem[slot] = e;
    end else if (want_user && !e[BIT_USER]) begin
      e[BIT_USER] = 1'b1;
      pt_mem[slot] = e;
    end
    // frame outside the pool counts as a missing level
    off = e[51:12] - pt_pool_base;
    if (off >= FRAME_W'(POOL_PAGES)) return -1;
    return int'(off);
  endfunction

  // Applies one request to the model and returns its result
  function automatic walk_resp_t table_walk(walk_req_t r);
    walk_resp_t res;
    logic [ENTRY_W-1:0] leaf;
    int pg;
    int lvl;
    int slot;
    bit create;
    bit want_user;
    res = '0;
    if (r.func == FN_NONE) return res;
    create = (r.func == FN_MAP);
    want_user = create && r.flags[BIT_USER];
    pg = 0;
    for (lvl = 0; lvl < 3; lvl++) begin
      pg = walk_level(pg, r.virt[VIRT_W-1-IDX_W*lvl -: IDX_W], create, want_user);
      if (pg < 0) return res;
    end
    slot = pg * ENTRIES_PER_TABLE + r.virt[20:12];
    leaf = pt_mem[slot];
    case (r.func)
      FN_MAP: begin
        leaf = {12'h0, r.phys_addr} | r.flags;
        leaf[BIT_PRESENT] = 1'b1;
        pt_mem[slot] = leaf;
        res.ok = 1'b1;
        res.invalidate = 1'b1;
      end
      FN_UNMAP: begin
        if (leaf[BIT_PRESENT]) begin
          pt_mem[slot] = '0;
          res.ok = 1'b1;
          res.invalidate = 1'b1;
        end
      end
      FN_LOOKUP: begin
        if (leaf[BIT_PRESENT]) begin
          res.ok = 1'b1;
          res.phys_out = leaf[PHYS_W-1:0] & ADDR_MASK[PHYS_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Index drawn from a small set so walks meet existing tables
  function automatic logic [IDX_W-1:0] pick_index(logic [IDX_W-1:0] alt);
    case ($urandom_range(2, 0))
      0: return '0;
      1: return '1;
      default: return alt;
    endcase
  endfunction

  function automatic walk_req_t make_request(bit noise);
    walk_req_t r;
    logic [IDX_W-1:0] i1;
    int unsigned w;
    if (noise) begin
      r.func = FUNC_W'($urandom_range(3, 0));
      r.virt = {16'($urandom), $urandom};
    end else begin
      w = $urandom_range(19, 0);
      if (w < 8) r.func = FN_MAP;
      else if (w < 15) r.func = FN_LOOKUP;
      else if (w < 19) r.func = FN_UNMAP;
      else r.func = FN_NONE;
      i1 = ($urandom_range(3, 0) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(3, 0));
      r.virt = {pick_index(9'h155), pick_index(9'h0AB), pick_index(9'h12C), i1,
                12'($urandom)};
    end
    r.phys_addr = PHYS_W'({$urandom, $urandom});
    if (r.phys_addr > PHYS_MAX) r.phys_addr = PHYS_MAX;
    r.flags = {$urandom, $urandom};
    r.drain_first = 1'b0;
    return r;
  endfunction

  task automatic push_req(logic [FUNC_W-1:0] func, logic [VIRT_W-1:0] virt,
                          logic [PHYS_W-1:0] phys, logic [FLAGS_W-1:0] flags);
    request_q.push_back('{func, virt, phys, flags, 1'b0});
  endtask

  // n random items, roughly one in ten pure noise; item pause_at waits for drain
  task automatic queue_random(int n, int pause_at);
    walk_req_t r;
    int i;
    for (i = 0; i < n; i++) begin
      r = make_request($urandom_range(9, 0) == 0);
      r.drain_first = (i == pause_at);
      request_q.push_back(r);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || walk_results_q.size() != 0 || in_tvalid);
  endtask

  task automatic set_pool_base(logic [FRAME_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    pt_pool_base = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    logic busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        walk_results_q.push_back(table_walk(cur_req));
        busy = 1'b0;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(24, 0) == 0) send_calm = $urandom_range(40, 8);
        send_gap = (send_calm > 0) ? 0 : $urandom_range(13, 0);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain_first && walk_results_q.size() > 0)) begin
          cur_req = request_q.pop_front();
          in_tdata <= {4'h0, cur_req.flags, cur_req.phys_addr, cur_req.virt};
          in_tuser <= cur_req.func;
          busy = 1'b1;
        end
      end
      in_tvalid <= busy;
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    walk_resp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (walk_results_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        end else begin
          want = walk_results_q.pop_front();
          if (out_tdata[0] !== want.ok) begin
            mismatch_count++;
            $display("%0t: ok expected %0h, got %0h", $time, want.ok, out_tdata[0]);
          end
          if (out_tdata[52:1] !== want.phys_out) begin
            mismatch_count++;
            $display("%0t: phys_out expected %h, got %h", $time, want.phys_out,
                     out_tdata[52:1]);
          end
          if (out_tdata[53] !== want.invalidate) begin
            mismatch_count++;
            $display("%0t: invalidate expected %0h, got %0h", $time, want.invalidate,
                     out_tdata[53]);
          end
        end
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(24, 0) == 0) recv_calm = $urandom_range(40, 8);
        recv_wait = (recv_calm > 0) ? 0 : $urandom_range(13, 0);
      end else if (out_tvalid && recv_wait > 0) begin
        recv_wait--;
      end
      out_tready <= (recv_wait == 0);
    end
  end

  // Watchdog: too long without any item moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int k;
    for (k = 0; k < POOL_PAGES*ENTRIES_PER_TABLE; k++) pt_mem[k] = '0;
    pt_next_page = 1;
    pt_pool_base = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Pool base at its top: new table frames wrap around to zero
    set_pool_base(BASE_MAX);
    push_req(FN_LOOKUP, '0, '0, '0);                    // empty root
    push_req(FN_UNMAP, '0, '0, '0);
    push_req(FN_MAP, '0, '0, '0);                       // three new tables
    push_req(FN_LOOKUP, '0, PHYS_MAX, '1);              // flags ignored
    push_req(FN_MAP, '1, PHYS_MAX, '1);                 // all ones, user tables
    push_req(FN_LOOKUP, '1, '0, '0);
    push_req(FN_MAP, 48'h1000, 52'h1_2345_6ABC, 64'h4); // user mark on old path
    push_req(FN_LOOKUP, 48'h1000, '0, '0);
    push_req(FN_UNMAP, 48'h1000, '1, '1);
    push_req(FN_LOOKUP, 48'h1000, '0, '0);              // leaf gone
    push_req(FN_UNMAP, 48'h1000, '0, '0);
    push_req(FN_NONE, '1, PHYS_MAX, '1);                // unused code
    push_req(FN_MAP, {9'h1FF, 9'h000, 9'h000, 9'h000, 12'h000}, 52'h5000, 64'h2);
    push_req(FN_LOOKUP, {9'h000, 9'h1FF, 9'h000, 9'h000, 12'h000}, '0, '0);
    push_req(FN_UNMAP, {9'h000, 9'h000, 9'h1FF, 9'h000, 12'h000}, '0, '0);
    push_req(FN_MAP, {9'h000, 9'h000, 9'h000, 9'h1FF, 12'hFFF}, 52'hA_BCDE_F012_3000,
             64'h8000_0000_0000_0180);                  // present forced, high bits
    push_req(FN_LOOKUP, {9'h000, 9'h000, 9'h000, 9'h1FF, 12'h000}, '0, '0);
    queue_random(450, 200);
    wait_drained();

    // Base at zero: old frames now alias other pool pages
    set_pool_base('0);
    queue_random(200, -1);
    wait_drained();

    // Random base: existing frames fall outside the pool
    set_pool_base({8'($urandom), $urandom});
    queue_random(80, -1);
    wait_drained();

    // Back to the original base; fresh top-level slots run the pool dry
    set_pool_base(BASE_MAX);
    for (k = 0; k < 6; k++)
      push_req(FN_MAP, {IDX_W'(16 + k), 9'h000, 9'h000, 9'h000, 12'h000}, 52'h7000, 64'h4);
    queue_random(300, 150);
    wait_drained();

    repeat (32) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
